FILE: hw/rtl/asgr_pkg.sv
// asgr_pkg: shared types, byte codes and the sgr decode function
// of the escape sequence parser; depends on nothing

package asgr_pkg;

    localparam int MAX_SEQ_LEN_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [7:0] ESC_BYTE   = 8'h1B;
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] CSI_BYTE   = 8'h5B;  // '['
    localparam logic [7:0] SEMI_BYTE  = 8'h3B;  // ';'
    localparam logic [7:0] TILDE_BYTE = 8'h7E;  // '~'
    localparam logic [7:0] SGR_FINAL  = 8'h6D;  // 'm'
    localparam logic [7:0] CLR_FINAL  = 8'h4A;  // 'J'
    localparam logic [7:0] DIGIT_0    = 8'h30;
    localparam logic [7:0] DIGIT_2    = 8'h32;
    localparam logic [7:0] DIGIT_3    = 8'h33;
    localparam logic [7:0] DIGIT_9    = 8'h39;

    localparam logic [4:0] FG_DEFAULT = 5'd16;
    localparam logic [4:0] BG_DEFAULT = 5'd17;
    localparam logic [4:0] FG_RESET   = 5'd7;

    localparam logic [1:0] KIND_PRINT = 2'd0;
    localparam logic [1:0] KIND_CR    = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // work items handed from the front to the back
    typedef enum logic [2:0] {
        OP_ESC,
        OP_PRINT,
        OP_CR,
        OP_SGR_END,
        OP_CLR_END,
        OP_DIGIT,
        OP_SEMI,
        OP_OTHER
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] chr;
    } t_token;

    // flags: bit 0 bold, bit 1 italic, bit 2 underline
    typedef struct packed {
        logic [4:0] fore;
        logic [4:0] back;
        logic [2:0] flags;
    } t_attr;

    function automatic logic is_final(input logic [7:0] c);
        logic upper;
        logic lower;
        upper = (c >= 8'h41) && (c <= 8'h5A);
        lower = (c >= 8'h61) && (c <= 8'h7A);
        return upper || lower || (c == TILDE_BYTE);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= DIGIT_0) && (c <= DIGIT_9);
    endfunction

    // one sgr code applied to a set of attributes
    function automatic t_attr apply_sgr(input t_attr a, input logic [7:0] code);
        t_attr      r;
        logic [7:0] d;
        r = a;
        d = 8'd0;
        if (code == 8'd0) begin
            r.fore  = FG_DEFAULT;
            r.back  = BG_DEFAULT;
            r.flags = 3'b000;
        end else if (code == 8'd1) begin
            r.flags = a.flags | 3'b001;
        end else if (code == 8'd3) begin
            r.flags = a.flags | 3'b010;
        end else if (code == 8'd4) begin
            r.flags = a.flags | 3'b100;
        end else if (code >= 8'd30 && code <= 8'd37) begin
            d      = code - 8'd30;
            r.fore = d[4:0];
        end else if (code == 8'd39) begin
            r.fore = FG_DEFAULT;
        end else if (code >= 8'd40 && code <= 8'd47) begin
            d      = code - 8'd40;
            r.back = d[4:0];
        end else if (code == 8'd49) begin
            r.back = BG_DEFAULT;
        end else if (code >= 8'd90 && code <= 8'd97) begin
            d      = code - 8'd82;
            r.fore = d[4:0];
        end else if (code >= 8'd100 && code <= 8'd107) begin
            d      = code - 8'd92;
            r.back = d[4:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/asgr_in_if.sv
// asgr_in_if: byte input channel, valid/ready with the character code
// depends on nothing

interface asgr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

FILE: hw/rtl/asgr_out_if.sv
// asgr_out_if: event output channel, valid/ready with kind, glyph and attributes
// depends on nothing

interface asgr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [7:0] glyph;
    logic [4:0] fore_index;
    logic [4:0] back_index;
    logic       bold_out;
    logic       italic_out;
    logic       underline_out;

    modport source (
        output valid, output event_kind, output glyph, output fore_index,
        output back_index, output bold_out, output italic_out, output underline_out,
        input ready
    );
    modport sink (
        input valid, input event_kind, input glyph, input fore_index,
        input back_index, input bold_out, input italic_out, input underline_out,
        output ready
    );
endinterface

FILE: hw/rtl/asgr_queue.sv
// asgr_queue: small token fifo between front and back
// depends on asgr_pkg

module asgr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  asgr_pkg::t_token  i_push_tok,
    output logic              o_full,
    output logic              o_valid,
    output asgr_pkg::t_token  o_pop_tok,
    input  logic              i_pop
);
    localparam int DEPTH = asgr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    asgr_pkg::t_token r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_pop_tok = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end
endmodule

FILE: hw/rtl/asgr_front.sv
// asgr_front: takes bytes, tracks sequence framing and length, emits tokens
// depends on asgr_pkg and asgr_in_if

module asgr_front #(
    parameter int MAX_SEQ_LEN = asgr_pkg::MAX_SEQ_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    asgr_in_if.sink           i_in,
    input  logic              i_q_full,
    output logic              o_push,
    output asgr_pkg::t_token  o_push_tok
);
    localparam int LEN_W = $clog2(MAX_SEQ_LEN + 1);

    logic             r_active;
    logic             r_csi;
    logic [LEN_W-1:0] r_len;

    logic             n_active;
    logic             n_csi;
    logic [LEN_W-1:0] n_len;
    logic             take;
    logic             at_limit;
    logic [7:0]       c;

    assign i_in.ready = !i_q_full;
    assign take       = i_in.valid && !i_q_full;
    assign c          = i_in.char_code;
    assign at_limit   = (r_len == LEN_W'(MAX_SEQ_LEN));

    always_comb begin
        n_active       = r_active;
        n_csi          = r_csi;
        n_len          = r_len;
        o_push         = 1'b0;
        o_push_tok.op  = asgr_pkg::OP_OTHER;
        o_push_tok.chr = c;
        if (take) begin
            priority if (c == asgr_pkg::ESC_BYTE) begin
                n_active      = 1'b1;
                n_csi         = 1'b0;
                n_len         = '0;
                o_push        = 1'b1;
                o_push_tok.op = asgr_pkg::OP_ESC;
            end else if (!r_active) begin
                o_push        = 1'b1;
                o_push_tok.op = (c == asgr_pkg::CR_BYTE) ? asgr_pkg::OP_CR
                                                          : asgr_pkg::OP_PRINT;
            end else if (asgr_pkg::is_final(c)) begin
                n_active = 1'b0;
                n_csi    = 1'b0;
                n_len    = '0;
                if (r_csi && c == asgr_pkg::SGR_FINAL) begin
                    o_push        = 1'b1;
                    o_push_tok.op = asgr_pkg::OP_SGR_END;
                end else if (r_csi && c == asgr_pkg::CLR_FINAL) begin
                    o_push        = 1'b1;
                    o_push_tok.op = asgr_pkg::OP_CLR_END;
                end
            end else if (at_limit) begin
                // over-long sequence dropped without trace
                n_active = 1'b0;
                n_csi    = 1'b0;
                n_len    = '0;
            end else begin
                n_len = r_len + LEN_W'(1);
                if (r_len == '0 && c == asgr_pkg::CSI_BYTE) begin
                    n_csi = 1'b1;
                end else if (r_csi) begin
                    o_push = 1'b1;
                    if (asgr_pkg::is_digit(c)) begin
                        o_push_tok.op = asgr_pkg::OP_DIGIT;
                    end else if (c == asgr_pkg::SEMI_BYTE) begin
                        o_push_tok.op = asgr_pkg::OP_SEMI;
                    end else begin
                        o_push_tok.op = asgr_pkg::OP_OTHER;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_csi    <= 1'b0;
            r_len    <= '0;
        end else begin
            r_active <= n_active;
            r_csi    <= n_csi;
            r_len    <= n_len;
        end
    end
endmodule

FILE: hw/rtl/asgr_back.sv
// asgr_back: runs tokens against parameter and attribute state, drives events
// depends on asgr_pkg and asgr_out_if

module asgr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  asgr_pkg::t_token  i_tok,
    output logic              o_pop,
    asgr_out_if.source        o_out
);
    localparam logic [1:0] PST_EMPTY  = 2'd0;
    localparam logic [1:0] PST_DIGITS = 2'd1;
    localparam logic [1:0] PST_BAD    = 2'd2;
    localparam logic [1:0] CM_NONE    = 2'd0;
    localparam logic [1:0] CM_MATCH   = 2'd1;
    localparam logic [1:0] CM_OTHER   = 2'd2;

    logic [7:0]      r_pval;
    logic [1:0]      r_pstat;
    logic [1:0]      r_cmatch;
    asgr_pkg::t_attr r_pend;
    asgr_pkg::t_attr r_cur;
    logic            r_vld;
    logic [1:0]      r_kind;
    logic [7:0]      r_glyph;
    asgr_pkg::t_attr r_oattr;

    logic [7:0]      n_pval;
    logic [1:0]      n_pstat;
    logic [1:0]      n_cmatch;
    asgr_pkg::t_attr n_pend;
    asgr_pkg::t_attr n_cur;
    logic            emit;
    logic [1:0]      emit_kind;
    logic            slot_free;
    logic [11:0]     pval_x10;
    logic [7:0]      digit;
    asgr_pkg::t_attr pend_applied;
    logic [1:0]      cmatch_step;

    assign slot_free    = !r_vld || o_out.ready;
    assign digit        = i_tok.chr - asgr_pkg::DIGIT_0;
    assign pval_x10     = ({4'd0, r_pval} << 3) + ({4'd0, r_pval} << 1) + {4'd0, digit};
    assign pend_applied = (r_pstat == PST_DIGITS) ? asgr_pkg::apply_sgr(r_pend, r_pval)
                                                  : r_pend;
    assign cmatch_step  = (r_cmatch == CM_NONE &&
                           (i_tok.chr == asgr_pkg::DIGIT_2 || i_tok.chr == asgr_pkg::DIGIT_3))
                          ? CM_MATCH : CM_OTHER;

    always_comb begin
        emit      = 1'b0;
        emit_kind = asgr_pkg::KIND_PRINT;
        n_pval    = r_pval;
        n_pstat   = r_pstat;
        n_cmatch  = r_cmatch;
        n_pend    = r_pend;
        n_cur     = r_cur;
        unique case (i_tok.op)
            asgr_pkg::OP_ESC: begin
                n_pval   = '0;
                n_pstat  = PST_EMPTY;
                n_cmatch = CM_NONE;
                n_pend   = r_cur;
            end
            asgr_pkg::OP_PRINT: begin
                emit = 1'b1;
            end
            asgr_pkg::OP_CR: begin
                emit      = 1'b1;
                emit_kind = asgr_pkg::KIND_CR;
            end
            asgr_pkg::OP_SGR_END: begin
                n_cur   = pend_applied;
                n_pval  = '0;
                n_pstat = PST_EMPTY;
            end
            asgr_pkg::OP_CLR_END: begin
                emit      = (r_cmatch == CM_MATCH);
                emit_kind = asgr_pkg::KIND_CLEAR;
            end
            asgr_pkg::OP_DIGIT: begin
                n_pval   = (pval_x10 > 12'd255) ? 8'd255 : pval_x10[7:0];
                n_pstat  = (r_pstat == PST_EMPTY) ? PST_DIGITS : r_pstat;
                n_cmatch = cmatch_step;
            end
            asgr_pkg::OP_SEMI: begin
                n_pend   = pend_applied;
                n_pval   = '0;
                n_pstat  = PST_EMPTY;
                n_cmatch = cmatch_step;
            end
            asgr_pkg::OP_OTHER: begin
                n_pstat  = PST_BAD;
                n_cmatch = cmatch_step;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // a token that raises an event waits for a free output slot
    assign o_pop = i_q_valid && (!emit || slot_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pval   <= '0;
            r_pstat  <= PST_EMPTY;
            r_cmatch <= CM_NONE;
            r_pend   <= '{fore: asgr_pkg::FG_RESET, back: asgr_pkg::BG_DEFAULT, flags: 3'b000};
            r_cur    <= '{fore: asgr_pkg::FG_RESET, back: asgr_pkg::BG_DEFAULT, flags: 3'b000};
            r_vld    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pval   <= n_pval;
                r_pstat  <= n_pstat;
                r_cmatch <= n_cmatch;
                r_pend   <= n_pend;
                r_cur    <= n_cur;
            end
            if (o_pop && emit) begin
                r_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_kind  <= emit_kind;
            r_glyph <= i_tok.chr;
            r_oattr <= r_cur;
        end
    end

    assign o_out.valid         = r_vld;
    assign o_out.event_kind    = r_kind;
    assign o_out.glyph         = r_glyph;
    assign o_out.fore_index    = r_oattr.fore;
    assign o_out.back_index    = r_oattr.back;
    assign o_out.bold_out      = r_oattr.flags[0];
    assign o_out.italic_out    = r_oattr.flags[1];
    assign o_out.underline_out = r_oattr.flags[2];
endmodule

FILE: hw/rtl/ansi_sgr_stream_parser.sv
// ansi_sgr_stream_parser: escape sequence parser with sgr attribute tracking
// throughput: one byte per cycle while the token queue is not full, set by the front and back stages
// the two-entry token queue lets a stalled output back up without dropping bytes
// reset: synchronous active-low; clears framing, queue and output valid,
// attributes return to foreground 7, background 17 and all styles off

module ansi_sgr_stream_parser #(
    parameter int MAX_SEQ_LEN = asgr_pkg::MAX_SEQ_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    asgr_in_if.sink     i_in,
    asgr_out_if.source  o_out
);
    // front to queue
    logic             push;
    asgr_pkg::t_token push_tok;
    logic             q_full;

    // queue to back
    logic             q_valid;
    asgr_pkg::t_token pop_tok;
    logic             pop;

    // front: frames sequences, counts their length and turns each byte
    // into a token; bytes with no effect (the csi opener, non-csi body,
    // other finals, the aborting byte) never reach the queue
    asgr_front #(
        .MAX_SEQ_LEN (MAX_SEQ_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_push_tok (push_tok)
    );

    // queue: decouples byte intake from the output handshake
    asgr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_tok (push_tok),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_pop_tok  (pop_tok),
        .i_pop      (pop)
    );

    // back: parameter accumulation, pending and current attributes,
    // and the registered output stage
    asgr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_tok     (pop_tok),
        .o_pop     (pop),
        .o_out     (o_out)
    );
endmodule

FILE: test/sgr_event_checker.sv
`timescale 1ns / 1ps
// sgr_event_checker: watches both channels of the escape sequence parser, predicts
// every event from the byte transfers and compares it field by field
// depends on asgr_pkg

module sgr_event_checker #(
    parameter int MAX_SEQ_LEN = asgr_pkg::MAX_SEQ_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_char,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_out_kind,
    input  logic [7:0] i_out_glyph,
    input  logic [4:0] i_out_fore,
    input  logic [4:0] i_out_back,
    input  logic       i_out_bold,
    input  logic       i_out_italic,
    input  logic       i_out_underline,
    output int         o_fail_count,
    output int         o_outstanding,
    output int         o_checked
);
    import asgr_pkg::*;

    typedef enum logic [1:0] {PARAM_EMPTY, PARAM_DIGITS, PARAM_MIXED} t_param_state;
    typedef enum logic [1:0] {CLR_NONE, CLR_EXACT, CLR_OTHER} t_clear_state;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] glyph;
        t_attr      attr;
    } t_event;

    logic         in_seq;
    logic [5:0]   seq_len;
    logic         is_csi;
    logic [7:0]   param_acc;
    t_param_state param_st;
    t_clear_state clear_st;
    t_attr        next_attr;
    t_attr        cur_attr;

    t_event       expected_events[$];
    int           failures;
    int           checked;

    function automatic t_attr render_code(input t_attr a, input int unsigned code);
        t_attr r;
        r = a;
        if (code == 0) begin
            r.fore  = FG_DEFAULT;
            r.back  = BG_DEFAULT;
            r.flags = 3'b000;
        end else if (code == 1) begin
            r.flags[0] = 1'b1;
        end else if (code == 3) begin
            r.flags[1] = 1'b1;
        end else if (code == 4) begin
            r.flags[2] = 1'b1;
        end else if (code >= 30 && code <= 37) begin
            r.fore = 5'(code - 30);
        end else if (code == 39) begin
            r.fore = FG_DEFAULT;
        end else if (code >= 40 && code <= 47) begin
            r.back = 5'(code - 40);
        end else if (code == 49) begin
            r.back = BG_DEFAULT;
        end else if (code >= 90 && code <= 97) begin
            r.fore = 5'(code - 90 + 8);
        end else if (code >= 100 && code <= 107) begin
            r.back = 5'(code - 100 + 8);
        end
        return r;
    endfunction

    task automatic clear_seq_state();
        seq_len   = '0;
        is_csi    = 1'b0;
        param_acc = '0;
        param_st  = PARAM_EMPTY;
        clear_st  = CLR_NONE;
    endtask

    task automatic close_param();
        if (param_st == PARAM_DIGITS)
            next_attr = render_code(next_attr, 32'(param_acc));
        param_acc = '0;
        param_st  = PARAM_EMPTY;
    endtask

    task automatic queue_event(input logic [1:0] kind, input logic [7:0] glyph);
        t_event ev;
        ev.kind  = kind;
        ev.glyph = glyph;
        ev.attr  = cur_attr;
        expected_events.push_back(ev);
    endtask

    task automatic parse_byte(input logic [7:0] c);
        logic        terminator;
        int unsigned acc;
        terminator = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == TILDE_BYTE;
        if (c == ESC_BYTE) begin
            in_seq = 1'b1;
            clear_seq_state();
            next_attr = cur_attr;
        end else if (!in_seq) begin
            queue_event((c == CR_BYTE) ? KIND_CR : KIND_PRINT, c);
        end else if (terminator) begin
            if (is_csi && c == SGR_FINAL) begin
                close_param();
                cur_attr = next_attr;
            end else if (is_csi && c == CLR_FINAL && clear_st == CLR_EXACT) begin
                queue_event(KIND_CLEAR, c);
            end
            in_seq = 1'b0;
            clear_seq_state();
        end else begin
            if (seq_len == 0 && c == CSI_BYTE) begin
                is_csi = 1'b1;
            end else if (is_csi) begin
                if (c >= DIGIT_0 && c <= DIGIT_9) begin
                    acc       = int'(param_acc) * 10 + int'(c - DIGIT_0);
                    param_acc = (acc > 255) ? 8'd255 : 8'(acc);
                    if (param_st == PARAM_EMPTY)
                        param_st = PARAM_DIGITS;
                end else if (c == SEMI_BYTE) begin
                    close_param();
                end else begin
                    param_st = PARAM_MIXED;
                end
                clear_st = (clear_st == CLR_NONE && (c == DIGIT_2 || c == DIGIT_3))
                           ? CLR_EXACT : CLR_OTHER;
            end
            seq_len = seq_len + 6'd1;
            // over-long sequence dropped without a trace
            if (seq_len > MAX_SEQ_LEN) begin
                in_seq = 1'b0;
                clear_seq_state();
            end
        end
    endtask

    task automatic report(input string what, input t_event want, input t_event got);
        failures++;
        if (failures <= 10) begin
            $display("%0t %s: expected kind %0d glyph %02h fore %0d back %0d uib %03b",
                     $time, what, want.kind, want.glyph, want.attr.fore, want.attr.back,
                     want.attr.flags);
            $display("    got kind %0d glyph %02h fore %0d back %0d uib %03b",
                     got.kind, got.glyph, got.attr.fore, got.attr.back, got.attr.flags);
        end
    endtask

    always @(posedge i_clk) begin
        t_event got;
        t_event want;
        if (!i_rst_n) begin
            in_seq = 1'b0;
            clear_seq_state();
            cur_attr.fore  = FG_RESET;
            cur_attr.back  = BG_DEFAULT;
            cur_attr.flags = 3'b000;
            next_attr      = cur_attr;
            expected_events.delete();
        end else begin
            // input first: an event never leaves in the cycle its byte arrives
            if (i_in_valid && i_in_ready)
                parse_byte(i_in_char);
            if (i_out_valid && i_out_ready) begin
                got.kind       = i_out_kind;
                got.glyph      = i_out_glyph;
                got.attr.fore  = i_out_fore;
                got.attr.back  = i_out_back;
                got.attr.flags = {i_out_underline, i_out_italic, i_out_bold};
                if (expected_events.size() == 0) begin
                    report("event with none pending", '0, got);
                end else begin
                    want = expected_events.pop_front();
                    checked++;
                    if (got.kind != want.kind || got.glyph != want.glyph
                        || got.attr.fore != want.attr.fore
                        || got.attr.back != want.attr.back
                        || got.attr.flags[0] != want.attr.flags[0]
                        || got.attr.flags[1] != want.attr.flags[1]
                        || got.attr.flags[2] != want.attr.flags[2])
                        report("event mismatch", want, got);
                end
            end
        end
        o_outstanding <= expected_events.size();
        o_fail_count  <= failures;
        o_checked     <= checked;
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// testbench: drives byte streams with escape sequences into the parser, stalls
// its event output and gives the verdict; depends on asgr_pkg, the two channel
// interfaces, ansi_sgr_stream_parser and sgr_event_checker

module testbench;
    import asgr_pkg::*;

    localparam int ITEM_TARGET  = 1500;
    localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
    localparam int IDLE_LIMIT   = 2000;  // cycles without any transfer
    localparam int DRAIN_CYCLES = 8;     // margin after the last event, plenty for the output register

    logic i_clk;
    logic i_rst_n;

    asgr_in_if  in_ch ();
    asgr_out_if out_ch ();

    logic [7:0] byte_q[$];   // bytes of the current scenario, waiting to go out
    int         sent_bytes;
    int         esc_count;
    int         burst_left;
    int         hold_count;
    int         pause_count;
    int         idle_cycles;
    logic       hold_req;    // stimulus asks the receiver for a long hold-off

    int         fail_count;
    int         outstanding;
    int         checked;

    ansi_sgr_stream_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sgr_event_checker event_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_ch.valid),
        .i_in_ready      (in_ch.ready),
        .i_in_char       (in_ch.char_code),
        .i_out_valid     (out_ch.valid),
        .i_out_ready     (out_ch.ready),
        .i_out_kind      (out_ch.event_kind),
        .i_out_glyph     (out_ch.glyph),
        .i_out_fore      (out_ch.fore_index),
        .i_out_back      (out_ch.back_index),
        .i_out_bold      (out_ch.bold_out),
        .i_out_italic    (out_ch.italic_out),
        .i_out_underline (out_ch.underline_out),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding),
        .o_checked       (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // byte sender: bursts of random length, random gaps in between;
    // a gap of zero joins two bursts so unbroken stretches occur too
    // ---------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid     <= 1'b1;
        in_ch.char_code <= b;
        // transfer happens at the first edge that sees ready high
        do @(posedge i_clk); while (!in_ch.ready);
        sent_bytes++;
        if (b == ESC_BYTE)
            esc_count++;
    endtask

    task automatic flush_bytes();
        while (byte_q.size() > 0)
            send_byte(byte_q.pop_front());
    endtask

    // stop offering until every predicted event has come out
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        pause_count++;
    endtask

    // ---------------------------------------------------------------
    // scenario building blocks
    // ---------------------------------------------------------------

    // decimal text, now and then with a leading zero
    function automatic void add_decimal(input int unsigned n);
        logic [7:0] digits[$];
        if (n == 0)
            digits.push_front(DIGIT_0);
        while (n > 0) begin
            digits.push_front(8'(DIGIT_0 + n % 10));
            n = n / 10;
        end
        if ($urandom_range(0, 9) == 0)
            digits.push_front(DIGIT_0);
        foreach (digits[i])
            byte_q.push_back(digits[i]);
    endfunction

    function automatic void add_printable();
        byte_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
    endfunction

    // characters that spoil a parameter without ending the sequence
    function automatic logic [7:0] odd_char();
        case ($urandom_range(0, 4))
            0:       return "+";
            1:       return "-";
            2:       return " ";
            3:       return ":";
            default: return "?";
        endcase
    endfunction

    function automatic logic [7:0] final_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'("A" + r);
        else if (r < 52)
            return 8'("a" + r - 26);
        return TILDE_BYTE;
    endfunction

    // any byte that neither ends nor restarts a sequence
    function automatic logic [7:0] seq_filler();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == TILDE_BYTE
            || c == ESC_BYTE)
            c = "?";
        return c;
    endfunction

    // up to four parameters: known codes, out-of-range values, large numbers
    // that saturate, empty fields and fields spoilt by a non-digit
    function automatic void add_sgr_params();
        int count;
        count = $urandom_range(0, 4);
        for (int i = 0; i < count; i++) begin
            if (i > 0)
                byte_q.push_back(SEMI_BYTE);
            case ($urandom_range(0, 13))
                0:  add_decimal(0);
                1:  add_decimal(1);
                2:  add_decimal(3);
                3:  add_decimal(4);
                4:  add_decimal(30 + $urandom_range(0, 9));
                5:  add_decimal(40 + $urandom_range(0, 9));
                6:  add_decimal(90 + $urandom_range(0, 9));
                7:  add_decimal(100 + $urandom_range(0, 9));
                8:  add_decimal(($urandom_range(0, 1) == 0) ? 39 : 49);
                9:  add_decimal($urandom_range(0, 255));
                10: add_decimal($urandom_range(256, 99999));
                11: ;  // empty field
                12: begin
                    byte_q.push_back(odd_char());
                    add_decimal($urandom_range(0, 49));
                end
                default: begin
                    add_decimal($urandom_range(0, 9));
                    byte_q.push_back(odd_char());
                end
            endcase
        end
    endfunction

    // ---------------------------------------------------------------
    // receiver: segments of full, mostly-ready and mostly-stalled
    // behaviour, plus the long hold-off on request
    // ---------------------------------------------------------------
    initial begin
        int seg_left;
        int mode;
        seg_left = 0;
        mode     = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_count++;
                hold_req = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(10, 80);
                end
                seg_left--;
                case (mode)
                    0, 1:    out_ch.ready <= 1'b1;
                    2:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // watchdog: any transfer on either side keeps the run alive
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // stimulus and verdict
    // ---------------------------------------------------------------
    initial begin
        int pick;
        int n;
        int next_hold;
        int next_pause;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.char_code <= 8'h00;
        hold_req    = 1'b0;
        sent_bytes  = 0;
        esc_count   = 0;
        burst_left  = 0;
        hold_count  = 0;
        pause_count = 0;
        idle_cycles = 0;
        next_hold   = ITEM_TARGET / 2;
        next_pause  = (2 * ITEM_TARGET) / 3;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: byte extremes, carriage return, a multi-parameter sgr with
        // bright colours, a high byte printed with them, a clear, an empty sgr
        byte_q = '{8'h00, 8'hFF, CR_BYTE,
                   ESC_BYTE, CSI_BYTE, "1", SEMI_BYTE, "9", "7", SEMI_BYTE,
                   "1", "0", "7", SGR_FINAL, 8'h80,
                   ESC_BYTE, CSI_BYTE, DIGIT_3, CLR_FINAL,
                   ESC_BYTE, CSI_BYTE, SGR_FINAL, "a"};
        flush_bytes();
        wait_drained();

        // receiver holds off while text keeps coming, so the block backs up
        hold_req = 1'b1;
        repeat (24) add_printable();
        flush_bytes();

        while (sent_bytes < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                // well-formed sgr, then a character that shows the result
                byte_q.push_back(ESC_BYTE);
                byte_q.push_back(CSI_BYTE);
                add_sgr_params();
                byte_q.push_back(SGR_FINAL);
                add_printable();
            end else if (pick < 42) begin
                // clear screen: only a lone 2 or 3 counts
                byte_q.push_back(ESC_BYTE);
                byte_q.push_back(CSI_BYTE);
                case ($urandom_range(0, 7))
                    0, 1: byte_q.push_back(DIGIT_2);
                    2, 3: byte_q.push_back(DIGIT_3);
                    4:    begin byte_q.push_back(DIGIT_2); byte_q.push_back(DIGIT_3); end
                    5:    ;
                    6:    begin byte_q.push_back(DIGIT_0); byte_q.push_back(DIGIT_2); end
                    default: begin byte_q.push_back(odd_char()); byte_q.push_back(DIGIT_3); end
                endcase
                byte_q.push_back(CLR_FINAL);
                add_printable();
            end else if (pick < 50) begin
                // csi with some other final, or junk in the parameters
                byte_q.push_back(ESC_BYTE);
                byte_q.push_back(CSI_BYTE);
                add_sgr_params();
                if ($urandom_range(0, 1) == 0)
                    byte_q.push_back(seq_filler());
                byte_q.push_back(final_letter());
                add_printable();
            end else if (pick < 56) begin
                // sequence that is not a csi
                byte_q.push_back(ESC_BYTE);
                n = $urandom_range(0, 3);
                repeat (n) byte_q.push_back(seq_filler());
                byte_q.push_back(final_letter());
                add_printable();
            end else if (pick < 62) begin
                // escape in the middle throws away the first attempt
                byte_q.push_back(ESC_BYTE);
                byte_q.push_back(CSI_BYTE);
                add_sgr_params();
                byte_q.push_back(ESC_BYTE);
                byte_q.push_back(CSI_BYTE);
                add_sgr_params();
                byte_q.push_back(SGR_FINAL);
                add_printable();
            end else if (pick < 66) begin
                // long parameter text either side of the abort length
                byte_q.push_back(ESC_BYTE);
                byte_q.push_back(CSI_BYTE);
                n = $urandom_range(28, 36);
                repeat (n)
                    byte_q.push_back(($urandom_range(0, 3) == 0) ? SEMI_BYTE
                                     : 8'(DIGIT_0 + $urandom_range(0, 9)));
                byte_q.push_back(SGR_FINAL);
                add_printable();
            end else if (pick < 76) begin
                // noise, escapes included
                n = $urandom_range(2, 10);
                repeat (n)
                    byte_q.push_back(($urandom_range(0, 3) == 0) ? ESC_BYTE
                                     : 8'($urandom_range(0, 255)));
            end else begin
                // plain text with carriage returns, any byte but escape
                n = $urandom_range(1, 8);
                repeat (n) begin
                    pick = $urandom_range(0, 255);
                    byte_q.push_back((pick == ESC_BYTE) ? CR_BYTE : 8'(pick));
                end
                if ($urandom_range(0, 3) == 0)
                    byte_q.push_back(CR_BYTE);
            end
            flush_bytes();

            if (sent_bytes >= next_hold) begin
                next_hold = ITEM_TARGET * 10;
                hold_req  = 1'b1;
                repeat (24) add_printable();
                flush_bytes();
            end
            if (sent_bytes >= next_pause) begin
                next_pause = ITEM_TARGET * 10;
                wait_drained();
            end
        end

        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d bytes (%0d escapes), %0d events compared, %0d mismatches",
                 sent_bytes, esc_count, checked, fail_count);
        $display("receiver hold-offs: %0d, sender drain pauses: %0d", hold_count, pause_count);
        if (fail_count == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
